/* hw/rtl/fmrc_pkg.sv */
package fmrc_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned NUM_FIELDS  = 4;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned CFG_W       = 3;

  // Input tdata layout, lowest bit first.
  localparam int unsigned PAT_LSB     = 0;
  localparam int unsigned CARE_LSB    = PAT_LSB + KEY_W;
  localparam int unsigned LOW_LSB     = CARE_LSB + KEY_W;
  localparam int unsigned HIGH_LSB    = LOW_LSB + NUM_FIELDS * FIELD_W;
  localparam int unsigned S_TDATA_W   = HIGH_LSB + NUM_FIELDS * FIELD_W;
  localparam int unsigned M_TDATA_W   = 16;

  // Parameter defaults.
  localparam int unsigned DEF_MAX_RULE_COUNT = 1024;
  localparam int unsigned DEF_MASK_WIDTH     = 32;
  localparam int unsigned DEF_RANGE_FIELDS   = 4;

  localparam logic [CFG_W-1:0] FIELDS_RESET = 3'd4;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

endpackage

/* hw/rtl/fmrc_ram.sv */
module fmrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/first_match_rule_classifier.sv */
// First-match rule classifier.
// Items arrive on the s_axis channel. tuser selects the kind: a load appends
// the rule in tdata to the rule table (no result; loads into a full table
// are dropped), a lookup scans the table in load order and sends one result
// on m_axis: tuser is the found flag, tdata the rule index.
// The rule table is a single-port-read RAM read one rule per cycle; each
// rule read is compared against the key by one shared mask and range
// comparator. A lookup passes from the accepting idle state through the scan
// state, where the registered RAM read of each rule is compared, to the emit
// state that loads the result register, ending the scan early at the first
// match. s_axis_tready_o is low while a lookup is in progress.
// One finished result is held in the output register. A new item is taken
// while it waits; a second lookup holds its result until m_axis_tready_i
// frees the register.
// The cfg channel writes fields_in_use (number of range fields compared) and
// is always ready. Reset empties the table (rule count zero) and sets
// fields_in_use to four; the RAM needs no clearing pass, since only entries
// below the rule count are ever read.
module first_match_rule_classifier #(
  parameter int unsigned MAX_RULE_COUNT = fmrc_pkg::DEF_MAX_RULE_COUNT,
  parameter int unsigned MASK_WIDTH     = fmrc_pkg::DEF_MASK_WIDTH,
  parameter int unsigned RANGE_FIELDS   = fmrc_pkg::DEF_RANGE_FIELDS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // pattern_bits, care_bits, low_or_value_0..3, high_0..3
  input  logic [fmrc_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // mode
  input  logic [0:0]                         s_axis_tuser_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // rule_index, zero padded
  output logic [fmrc_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // found
  output logic [0:0]                         m_axis_tuser_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  input  logic [fmrc_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o
);

  import fmrc_pkg::*;

  localparam int unsigned AW    = (MAX_RULE_COUNT > 1) ? $clog2(MAX_RULE_COUNT) : 1;
  localparam int unsigned CW    = $clog2(MAX_RULE_COUNT + 1);
  localparam int unsigned CMP_W = (MASK_WIDTH < KEY_W) ? MASK_WIDTH : KEY_W;
  localparam int unsigned RNG_W = RANGE_FIELDS * FIELD_W;
  localparam int unsigned WORD_W = 2 * CMP_W + 2 * RNG_W;
  localparam int unsigned XW    = AW + IDX_W;

  // RAM word layout, lowest bit first: pattern, care, lows, highs.
  localparam int unsigned W_CARE = CMP_W;
  localparam int unsigned W_LOW  = 2 * CMP_W;
  localparam int unsigned W_HIGH = 2 * CMP_W + RNG_W;

  state_e state_q, state_d;

  logic [CW-1:0]      count_q;
  logic [CW-1:0]      addr_q;
  logic               rd_vld_q;
  logic [AW-1:0]      rd_idx_q;
  logic               hit_q;
  logic [AW-1:0]      hit_idx_q;
  logic [CMP_W-1:0]   key_q;
  logic [FIELD_W-1:0] val_q [RANGE_FIELDS];
  logic [CFG_W-1:0]   fields_q;
  logic               m_valid_q;
  logic               m_found_q;
  logic [IDX_W-1:0]   m_idx_q;

  logic               s_hs;
  logic               is_load;
  logic               ram_we;
  logic               ram_re;
  logic               out_free;
  logic               out_load;
  logic               match;
  logic [WORD_W-1:0]  wr_word;
  logic [WORD_W-1:0]  rd_word;
  logic [RANGE_FIELDS-1:0] lane_ok;
  logic [XW-1:0]      idx_ext;

  assign s_hs     = s_axis_tvalid_i && s_axis_tready_o;
  assign is_load  = (s_axis_tuser_i[0] == MODE_LOAD);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    wr_word = '0;
    wr_word[CMP_W-1:0]          = s_axis_tdata_i[PAT_LSB +: CMP_W];
    wr_word[W_CARE +: CMP_W]    = s_axis_tdata_i[CARE_LSB +: CMP_W];
    for (int i = 0; i < RANGE_FIELDS; i++) begin
      wr_word[W_LOW + i*FIELD_W +: FIELD_W]  = s_axis_tdata_i[LOW_LSB + i*FIELD_W +: FIELD_W];
      wr_word[W_HIGH + i*FIELD_W +: FIELD_W] = s_axis_tdata_i[HIGH_LSB + i*FIELD_W +: FIELD_W];
    end
  end

  fmrc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_RULE_COUNT)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_word),
    .re_i    (ram_re),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (rd_word)
  );

  // Shared comparator: one stored rule against the key per cycle.
  for (genvar g = 0; g < RANGE_FIELDS; g++) begin : g_lane
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    logic               in_use;
    assign lo     = rd_word[W_LOW + g*FIELD_W +: FIELD_W];
    assign hi     = rd_word[W_HIGH + g*FIELD_W +: FIELD_W];
    assign in_use = (CFG_W'(g) < fields_q);
    assign lane_ok[g] = !in_use || ((val_q[g] >= lo) && (val_q[g] <= hi));
  end

  assign match = (((rd_word[CMP_W-1:0] ^ key_q) & rd_word[W_CARE +: CMP_W]) == '0)
                 && (&lane_ok);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_hs && !is_load) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && match) begin
          state_d = ST_EMIT;
        end else if ((addr_q == count_q) && !rd_vld_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        ram_we = s_axis_tvalid_i && is_load && (count_q < CW'(MAX_RULE_COUNT));
      end
      ST_SCAN: begin
        ram_re = (addr_q < count_q) && !(rd_vld_q && match);
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  assign idx_ext = XW'(hit_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      addr_q    <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      fields_q  <= FIELDS_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ram_re;
      if (cfg_valid_i && cfg_ready_o) begin
        fields_q <= cfg_data_i;
      end
      if (ram_we) begin
        count_q <= count_q + CW'(1);
      end
      if (s_hs && !is_load) begin
        addr_q <= '0;
        hit_q  <= 1'b0;
      end else if (ram_re) begin
        addr_q <= addr_q + CW'(1);
      end
      if (state_q == ST_SCAN && rd_vld_q && match) begin
        hit_q <= 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_hs && !is_load) begin
      key_q     <= s_axis_tdata_i[PAT_LSB +: CMP_W];
      hit_idx_q <= '0;
      for (int i = 0; i < RANGE_FIELDS; i++) begin
        val_q[i] <= s_axis_tdata_i[LOW_LSB + i*FIELD_W +: FIELD_W];
      end
    end else if (state_q == ST_SCAN && rd_vld_q && match) begin
      hit_idx_q <= rd_idx_q;
    end
    if (ram_re) begin
      rd_idx_q <= addr_q[AW-1:0];
    end
    if (out_load) begin
      m_found_q <= hit_q;
      m_idx_q   <= idx_ext[IDX_W-1:0];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_found_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - IDX_W)'(0), m_idx_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_RULE_COUNT))
    else $error("rule count above table size");

  a_scan_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (addr_q <= count_q))
    else $error("scan address beyond rule count");

  a_hit_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && hit_q) |-> (CW'(hit_idx_q) < count_q))
    else $error("matched index not a stored rule");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_hs && is_load && count_q == CW'(MAX_RULE_COUNT)) |=> (count_q == $past(count_q)))
    else $error("load into a full table changed the rule count");

  a_emit_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && m_valid_q && !m_axis_tready_i) |=> (state_q == ST_EMIT))
    else $error("result left the scan while the output register was full");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import fmrc_pkg::*;

  typedef struct {
    mode_e                              mode;
    logic [KEY_W-1:0]                   pattern;
    logic [KEY_W-1:0]                   care;
    logic [NUM_FIELDS-1:0][FIELD_W-1:0] lo;
    logic [NUM_FIELDS-1:0][FIELD_W-1:0] hi;
  } rule_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } answer_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic [S_TDATA_W-1:0]   s_axis_tdata_i  = '0;
  logic [0:0]             s_axis_tuser_i  = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [M_TDATA_W-1:0]   m_axis_tdata_o;
  logic [0:0]             m_axis_tuser_o;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [CFG_W-1:0]       cfg_data_i      = '0;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;

  // Our own copy of the rule table and the field setting.
  logic [KEY_W-1:0]                   tbl_pattern [DEF_MAX_RULE_COUNT];
  logic [KEY_W-1:0]                   tbl_care    [DEF_MAX_RULE_COUNT];
  logic [NUM_FIELDS-1:0][FIELD_W-1:0] tbl_lo      [DEF_MAX_RULE_COUNT];
  logic [NUM_FIELDS-1:0][FIELD_W-1:0] tbl_hi      [DEF_MAX_RULE_COUNT];
  int unsigned                        rule_total  = 0;
  logic [CFG_W-1:0]                   fields_cfg  = FIELDS_RESET;

  answer_t     answer_q [$];
  answer_t     want;
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  int unsigned rx_mode    = 0;
  int unsigned rx_left    = 0;
  int unsigned stall_left = 0;

  first_match_rule_classifier u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_data_i      (cfg_data_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_500_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [S_TDATA_W-1:0] pack_item(input rule_item_t it);
    logic [S_TDATA_W-1:0] d;
    d = '0;
    d[PAT_LSB +: KEY_W]  = it.pattern;
    d[CARE_LSB +: KEY_W] = it.care;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      d[LOW_LSB + FIELD_W * f +: FIELD_W]  = it.lo[f];
      d[HIGH_LSB + FIELD_W * f +: FIELD_W] = it.hi[f];
    end
    return d;
  endfunction

  function automatic rule_item_t mk_item(input mode_e m, input logic [KEY_W-1:0] pat,
                                         input logic [KEY_W-1:0] care,
                                         input logic [NUM_FIELDS*FIELD_W-1:0] lo,
                                         input logic [NUM_FIELDS*FIELD_W-1:0] hi);
    rule_item_t it;
    it.mode    = m;
    it.pattern = pat;
    it.care    = care;
    it.lo      = lo;
    it.hi      = hi;
    return it;
  endfunction

  // First rule in load order whose cared bits equal the key and whose
  // in-use ranges all hold the key values.
  function automatic answer_t classify_key(input rule_item_t key);
    answer_t     a;
    int unsigned used;
    bit          hit;
    a    = '0;
    used = (fields_cfg > NUM_FIELDS) ? NUM_FIELDS : fields_cfg;
    for (int unsigned r = 0; r < rule_total; r++) begin
      hit = ((tbl_pattern[r] ^ key.pattern) & tbl_care[r]) == '0;
      for (int unsigned f = 0; f < used; f++) begin
        if (key.lo[f] < tbl_lo[r][f] || key.lo[f] > tbl_hi[r][f]) hit = 1'b0;
      end
      if (hit) begin
        a.found = 1'b1;
        a.idx   = r[IDX_W-1:0];
        return a;
      end
    end
    return a;
  endfunction

  function automatic void store_rule(input rule_item_t it);
    if (rule_total < DEF_MAX_RULE_COUNT) begin
      tbl_pattern[rule_total] = it.pattern;
      tbl_care[rule_total]    = it.care;
      tbl_lo[rule_total]      = it.lo;
      tbl_hi[rule_total]      = it.hi;
      rule_total++;
    end
  endfunction

  function automatic rule_item_t random_rule();
    rule_item_t         it;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    it.mode    = MODE_LOAD;
    it.pattern = $urandom();
    case ($urandom_range(0, 5))
      0: it.care = '1;
      1: it.care = '0;
      2: it.care = $urandom() & $urandom() & $urandom();
      3: it.care = 32'h1 << $urandom_range(0, 31);
      default: it.care = $urandom();
    endcase
    for (int f = 0; f < NUM_FIELDS; f++) begin
      a = FIELD_W'($urandom());
      b = FIELD_W'($urandom());
      case ($urandom_range(0, 7))
        0: begin
          it.lo[f] = '0;
          it.hi[f] = '1;
        end
        1: begin
          it.lo[f] = a;
          it.hi[f] = a;
        end
        2: begin
          // Empty range unless a equals b: the rule can then only match while this field is unused.
          it.lo[f] = (a > b) ? a : b;
          it.hi[f] = (a > b) ? b : a;
        end
        3: begin
          it.lo[f] = a;
          it.hi[f] = (a > 16'hFFC0) ? 16'hFFFF : a + FIELD_W'($urandom_range(0, 63));
        end
        default: begin
          it.lo[f] = (a < b) ? a : b;
          it.hi[f] = (a < b) ? b : a;
        end
      endcase
    end
    return it;
  endfunction

  // Most keys are aimed at a stored rule, often on its range bounds; the rest
  // are noise or just miss one range.
  function automatic rule_item_t random_key();
    rule_item_t  it;
    int unsigned r;
    int unsigned fm;
    it.mode    = MODE_LOOKUP;
    it.pattern = $urandom();
    it.care    = $urandom();
    for (int f = 0; f < NUM_FIELDS; f++) begin
      it.lo[f] = FIELD_W'($urandom());
      it.hi[f] = FIELD_W'($urandom());
    end
    if (rule_total != 0 && $urandom_range(0, 9) < 8) begin
      r = $urandom_range(0, rule_total - 1);
      it.pattern = (tbl_pattern[r] & tbl_care[r]) | (it.pattern & ~tbl_care[r]);
      for (int f = 0; f < NUM_FIELDS; f++) begin
        if (tbl_lo[r][f] <= tbl_hi[r][f]) begin
          case ($urandom_range(0, 3))
            0: it.lo[f] = tbl_lo[r][f];
            1: it.lo[f] = tbl_hi[r][f];
            default: it.lo[f] = FIELD_W'($urandom_range(tbl_lo[r][f], tbl_hi[r][f]));
          endcase
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        fm = $urandom_range(0, NUM_FIELDS - 1);
        if (tbl_hi[r][fm] != '1) it.lo[fm] = tbl_hi[r][fm] + 1'b1;
      end
    end
    return it;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic send_item(input rule_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tdata_i  <= pack_item(it);
    s_axis_tuser_i  <= it.mode;
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (it.mode == MODE_LOOKUP) answer_q = {answer_q, classify_key(it)};
    else store_rule(it);
  endtask

  // Hold off new requests until every lookup has answered and a load that
  // may still be in flight has settled.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_fields(input logic [CFG_W-1:0] v);
    wait_idle();
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    fields_cfg = v;
  endtask

  task automatic run_random_traffic(input int unsigned count);
    rule_item_t it;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 35) it = random_rule();
      else it = random_key();
      send_item(it);
    end
  endtask

  task automatic test_empty_table();
    send_item(mk_item(MODE_LOOKUP, '0, '0, '0, '0));
    send_item(mk_item(MODE_LOOKUP, '1, '1, '1, '1));
  endtask

  task automatic test_priority_and_wildcards();
    // Rule 0: exact all-ones pattern, full ranges.
    send_item(mk_item(MODE_LOAD, '1, '1, '0, '1));
    // Rule 1: all wildcard bits, every range a single point at zero.
    send_item(mk_item(MODE_LOAD, '0, '0, '0, '0));
    // Rule 2: upper half cared, every range empty.
    send_item(mk_item(MODE_LOAD, 32'h1234_5678, 32'hFFFF_0000, '1, '0));
    // Rule 3: lower half cared, ranges 0x1000..0x2000.
    send_item(mk_item(MODE_LOAD, 32'h0000_A5A5, 32'h0000_FFFF,
                      {4{16'h1000}}, {4{16'h2000}}));
    // Rule 4: catch-all.
    send_item(mk_item(MODE_LOAD, '0, '0, '0, '1));
    send_item(mk_item(MODE_LOOKUP, '1, '0, '1, '0));
    send_item(mk_item(MODE_LOOKUP, 32'hFFFF_FFFE, '1, '0, '1));
    send_item(mk_item(MODE_LOOKUP, 32'h1234_A5A5, '0, {4{16'h1500}}, '0));
    send_item(mk_item(MODE_LOOKUP, 32'h0000_A5A5, '0, {4{16'h1000}}, '0));
    send_item(mk_item(MODE_LOOKUP, 32'h0000_A5A5, '0, {4{16'h2000}}, '0));
    send_item(mk_item(MODE_LOOKUP, 32'h0000_A5A5, '0, {4{16'h2001}}, '0));
    send_item(mk_item(MODE_LOOKUP, 32'h0000_A5A5, '0, {4{16'h0FFF}}, '0));
    // With no range fields in use only the mask decides, so the all-wildcard rule 1 hits every key.
    write_fields(3'd0);
    send_item(mk_item(MODE_LOOKUP, 32'h1234_A5A5, '0, '1, '0));
    send_item(mk_item(MODE_LOOKUP, 32'h0000_0000, '0, '1, '0));
    write_fields(3'd1);
    send_item(mk_item(MODE_LOOKUP, 32'h0000_A5A5, '0,
                      {{3{16'hFFFF}}, 16'h1500}, '0));
    send_item(mk_item(MODE_LOOKUP, 32'h0000_A5A5, '0,
                      {{3{16'h1500}}, 16'hFFFF}, '0));
  endtask

  task automatic test_field_settings();
    logic [CFG_W-1:0] settings [8] = '{3'd0, 3'd7, 3'd2, 3'd5, 3'd1, 3'd6, 3'd3, 3'd4};
    foreach (settings[i]) begin
      write_fields(settings[i]);
      run_random_traffic(70);
    end
  endtask

  task automatic test_full_table();
    while (rule_total < DEF_MAX_RULE_COUNT) begin
      if (rule_total == DEF_MAX_RULE_COUNT - 1)
        send_item(mk_item(MODE_LOAD, 32'hA500_0000 | rule_total, '1, '1, '1));
      else
        send_item(mk_item(MODE_LOAD, 32'hA500_0000 | rule_total, '1, '0, '1));
    end
    // A full table drops further loads; a catch-all here must not show up.
    repeat (3) send_item(mk_item(MODE_LOAD, '0, '0, '0, '1));
    send_item(mk_item(MODE_LOOKUP, 32'hA500_03FF, '0, '1, '0));
    send_item(mk_item(MODE_LOOKUP, 32'hA500_03FF, '0, {4{16'h0001}}, '0));
    send_item(mk_item(MODE_LOOKUP, 32'h5A5A_5A5A, '0, {4{16'h7777}}, '0));
    repeat (5) send_item(random_key());
  endtask

  // Result side: check every accepted result, then drive the stall pattern.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (answer_q.size() == 0) begin
        note_failure($sformatf("result with no lookup pending: found=%0b tdata=%0h",
                               m_axis_tuser_o, m_axis_tdata_o));
      end else begin
        want = answer_q.pop_front();
        if (m_axis_tuser_o[0] !== want.found ||
            m_axis_tdata_o !== {{(M_TDATA_W-IDX_W){1'b0}}, want.idx}) begin
          note_failure($sformatf("expected found=%0b index=%0d, got found=%0b tdata=%0h",
                                 want.found, want.idx, m_axis_tuser_o, m_axis_tdata_o));
        end
      end
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(10, 200);
    end
    rx_left--;
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 20);
            m_axis_tready_i <= 1'b0;
          end else begin
            m_axis_tready_i <= 1'b1;
          end
        end
      endcase
    end
  end

  initial begin
    int unsigned drain_cycles;
    drain_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_priority_and_wildcards();
    test_field_settings();
    test_full_table();
    s_axis_tvalid_i <= 1'b0;
    while (answer_q.size() != 0 && drain_cycles < 4000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (16) @(posedge clk_i);
    if (answer_q.size() != 0)
      note_failure($sformatf("%0d lookups never answered", answer_q.size()));
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* first_match_rule_classifier.f */
hw/rtl/fmrc_pkg.sv
hw/rtl/fmrc_ram.sv
hw/rtl/first_match_rule_classifier.sv
test/testbench.sv
